### rtl/assert_macros.svh
// Assertion helpers for the ARQ controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ARQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ARQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ARQ_ASSERT(lbl, clk, rst_n, prop)
`define ARQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/arq_pkg.sv
package arq_pkg;

    localparam int SEQ_BITS     = 3;
    localparam int WINDOW_SLOTS = 4;
    localparam int SLOT_BITS    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_BITS     = $clog2(WINDOW_SLOTS + 1);
    localparam int MODE_BITS    = 3;
    localparam int ACT_BITS     = 3;

    localparam logic KIND_DATA = 1'b0;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PKT_READY    = 3'd0,
        MODE_LINK_READY   = 3'd1,
        MODE_FRAME_RX     = 3'd2,
        MODE_ACK_TIMEOUT  = 3'd3,
        MODE_DATA_TIMEOUT = 3'd4
    } t_mode;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_STATUS    = 3'd0,
        ACT_SEND_DATA = 3'd1,
        ACT_SEND_ACK  = 3'd2,
        ACT_DELIVER   = 3'd3,
        ACT_STOP      = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_ACK,
        S_DELIVER,
        S_ACKF,
        S_STATUS
    } t_state;

    typedef struct packed {
        t_action               action;
        logic [SEQ_BITS-1:0]   seq;
        logic [SEQ_BITS-1:0]   ack;
        logic [SLOT_BITS-1:0]  slot;
        logic                  en;
        logic                  last;
    } t_result;

endpackage

### rtl/arq_win_unit.sv
module arq_win_unit (
    input  logic [arq_pkg::SEQ_BITS-1:0] i_lo,
    input  logic [arq_pkg::SEQ_BITS-1:0] i_x,
    input  logic [arq_pkg::SEQ_BITS-1:0] i_hi,
    output logic                         o_hit,
    output logic [arq_pkg::SEQ_BITS-1:0] o_lo_inc
);

    always_comb begin
        if (i_lo <= i_hi) begin
            o_hit = (i_lo <= i_x) && (i_x < i_hi);
        end else begin
            o_hit = (i_lo <= i_x) || (i_x < i_hi);
        end
    end

    assign o_lo_inc = i_lo + arq_pkg::SEQ_BITS'(1);

endmodule

### rtl/arq_ctrl.sv
`include "assert_macros.svh"

module arq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [arq_pkg::MODE_BITS-1:0] i_mode,
    input  logic                          i_frame_kind,
    input  logic [arq_pkg::SEQ_BITS-1:0]  i_frame_seq,
    input  logic [arq_pkg::SEQ_BITS-1:0]  i_frame_ack,
    input  logic                          i_frame_good,
    input  logic                          i_out_ready,
    output logic                          o_emit,
    output arq_pkg::t_result              o_res
);

    arq_pkg::t_state r_state, n_state;

    logic [arq_pkg::SEQ_BITS-1:0] r_oldest, n_oldest;
    logic [arq_pkg::SEQ_BITS-1:0] r_next, n_next;
    logic [arq_pkg::SEQ_BITS-1:0] r_exp, n_exp;
    logic [arq_pkg::CNT_BITS-1:0] r_count, n_count;
    logic                         r_link, n_link;
    logic [arq_pkg::SEQ_BITS-1:0] r_seq, n_seq;
    logic [arq_pkg::CNT_BITS-1:0] r_left, n_left;

    logic                         r_kind;
    logic [arq_pkg::SEQ_BITS-1:0] r_fseq;
    logic [arq_pkg::SEQ_BITS-1:0] r_fack;

    logic [arq_pkg::SEQ_BITS-1:0] w_lo;
    logic [arq_pkg::SEQ_BITS-1:0] w_lo_inc;
    logic                         w_hit;
    logic                         w_retire;
    logic                         w_deliver;
    logic                         w_room;
    logic                         w_fire;
    logic [arq_pkg::SEQ_BITS-1:0] w_ack_val;

    always_comb begin
        case (r_state)
            arq_pkg::S_ACK:  w_lo = r_oldest;
            arq_pkg::S_IDLE: w_lo = r_next;
            default:         w_lo = r_seq;
        endcase
    end

    arq_win_unit u_win (
        .i_lo     (w_lo),
        .i_x      (r_fack),
        .i_hi     (r_next),
        .o_hit    (w_hit),
        .o_lo_inc (w_lo_inc)
    );

    assign w_retire  = (r_count != '0) && w_hit;
    assign w_deliver = (r_kind == arq_pkg::KIND_DATA) && (r_fseq == r_exp);
    assign w_room    = r_count < arq_pkg::CNT_BITS'(arq_pkg::WINDOW_SLOTS);
    assign w_fire    = o_emit && i_out_ready;
    assign w_ack_val = r_exp - arq_pkg::SEQ_BITS'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            arq_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        arq_pkg::MODE_PKT_READY:    n_state = arq_pkg::S_SEND;
                        arq_pkg::MODE_DATA_TIMEOUT: n_state = arq_pkg::S_SEND;
                        arq_pkg::MODE_FRAME_RX: begin
                            n_state = i_frame_good ? arq_pkg::S_ACK : arq_pkg::S_STATUS;
                        end
                        arq_pkg::MODE_ACK_TIMEOUT:  n_state = arq_pkg::S_ACKF;
                        default:                    n_state = arq_pkg::S_STATUS;
                    endcase
                end
            end
            arq_pkg::S_SEND: begin
                if (r_left == '0) begin
                    n_state = arq_pkg::S_STATUS;
                end
            end
            arq_pkg::S_ACK: begin
                if (!w_retire) begin
                    n_state = w_deliver ? arq_pkg::S_DELIVER : arq_pkg::S_STATUS;
                end
            end
            arq_pkg::S_DELIVER: begin
                if (w_fire) begin
                    n_state = arq_pkg::S_STATUS;
                end
            end
            arq_pkg::S_ACKF: begin
                if (w_fire) begin
                    n_state = arq_pkg::S_STATUS;
                end
            end
            arq_pkg::S_STATUS: begin
                if (w_fire) begin
                    n_state = arq_pkg::S_IDLE;
                end
            end
            default: n_state = arq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_emit  = 1'b0;
        o_res   = '0;
        case (r_state)
            arq_pkg::S_IDLE: o_ready = 1'b1;
            arq_pkg::S_SEND: begin
                if (r_left != '0) begin
                    o_emit        = 1'b1;
                    o_res.action  = arq_pkg::ACT_SEND_DATA;
                    o_res.seq     = r_seq;
                    o_res.ack     = w_ack_val;
                    o_res.slot    = arq_pkg::SLOT_BITS'(r_seq % arq_pkg::WINDOW_SLOTS);
                end
            end
            arq_pkg::S_ACK: begin
                if (w_retire) begin
                    o_emit       = 1'b1;
                    o_res.action = arq_pkg::ACT_STOP;
                    o_res.seq    = r_oldest;
                end
            end
            arq_pkg::S_DELIVER: begin
                o_emit       = 1'b1;
                o_res.action = arq_pkg::ACT_DELIVER;
                o_res.seq    = r_fseq;
            end
            arq_pkg::S_ACKF: begin
                o_emit       = 1'b1;
                o_res.action = arq_pkg::ACT_SEND_ACK;
                o_res.ack    = w_ack_val;
            end
            arq_pkg::S_STATUS: begin
                o_emit       = 1'b1;
                o_res.action = arq_pkg::ACT_STATUS;
                o_res.en     = w_room && r_link;
                o_res.last   = 1'b1;
            end
            default: o_emit = 1'b0;
        endcase
    end

    // window and receive pointers
    always_comb begin
        n_oldest = r_oldest;
        n_next   = r_next;
        n_exp    = r_exp;
        n_count  = r_count;
        n_link   = r_link;
        n_seq    = r_seq;
        n_left   = r_left;
        case (r_state)
            arq_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        arq_pkg::MODE_PKT_READY: begin
                            n_seq = r_next;
                            if (w_room) begin
                                n_left  = arq_pkg::CNT_BITS'(1);
                                n_count = r_count + arq_pkg::CNT_BITS'(1);
                                n_next  = w_lo_inc;
                            end else begin
                                n_left = '0;
                            end
                        end
                        arq_pkg::MODE_DATA_TIMEOUT: begin
                            n_seq  = r_oldest;
                            n_left = r_count;
                        end
                        arq_pkg::MODE_LINK_READY: n_link = 1'b1;
                        default: n_left = r_left;
                    endcase
                end
            end
            arq_pkg::S_SEND: begin
                if (w_fire) begin
                    n_seq  = w_lo_inc;
                    n_left = r_left - arq_pkg::CNT_BITS'(1);
                    n_link = 1'b0;
                end
            end
            arq_pkg::S_ACK: begin
                if (w_fire) begin
                    n_count  = r_count - arq_pkg::CNT_BITS'(1);
                    n_oldest = w_lo_inc;
                end
            end
            arq_pkg::S_DELIVER: begin
                if (w_fire) begin
                    n_exp = r_exp + arq_pkg::SEQ_BITS'(1);
                end
            end
            arq_pkg::S_ACKF: begin
                if (w_fire) begin
                    n_link = 1'b0;
                end
            end
            default: n_link = r_link;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= arq_pkg::S_IDLE;
            r_oldest <= '0;
            r_next   <= '0;
            r_exp    <= '0;
            r_count  <= '0;
            r_link   <= 1'b0;
            r_seq    <= '0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_next   <= n_next;
            r_exp    <= n_exp;
            r_count  <= n_count;
            r_link   <= n_link;
            r_seq    <= n_seq;
            r_left   <= n_left;
        end
    end

    // hold the received frame fields for the whole transaction
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= i_frame_kind;
            r_fseq <= i_frame_seq;
            r_fack <= i_frame_ack;
        end
    end

    `ARQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= arq_pkg::CNT_BITS'(arq_pkg::WINDOW_SLOTS))
    `ARQ_ASSERT(a_count_span, i_clk, i_rst_n, arq_pkg::SEQ_BITS'(r_next - r_oldest) == arq_pkg::SEQ_BITS'(r_count))
    `ARQ_ASSERT(a_stop_nonempty, i_clk, i_rst_n, !(o_emit && o_res.action == arq_pkg::ACT_STOP) || r_count != '0)
    `ARQ_ASSERT_NEXT(a_status_ends, i_clk, i_rst_n, w_fire && r_state == arq_pkg::S_STATUS, r_state == arq_pkg::S_IDLE)

endmodule

### rtl/arq_out_reg.sv
module arq_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  arq_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output arq_pkg::t_result o_res
);

    logic             r_valid;
    arq_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/go_back_n_arq_controller_top.sv
// Go-Back-N ARQ sequence controller with piggybacked acknowledgements.
// Input channel (i_valid/o_ready) carries one link event per transaction:
// packet ready, link ready, frame received (kind, seq, ack, check result),
// ack timeout or data timeout. Output channel (o_valid/i_ready) returns a run
// of action items - send data, send ack, stop timer, deliver - closed by one
// status item with o_last high that carries the network-layer enable.
// One event is handled at a time; o_ready is high only between events.
// A small sequencer drives one shared window-compare/increment unit, giving
// one action item per cycle while the output is not stalled: retiring acks
// and resends walk the window one frame a cycle. An event is accepted in
// idle; the sequencer then emits its action items and the status item, with
// an extra step that closes the walk on packet-ready, data-timeout and good
// frame-received events. Items pass through a single output register, so a
// stalled receiver (i_ready low) simply holds the sequencer; nothing is
// dropped.
// Reset (i_rst_n low, synchronous) clears all window pointers, the buffered
// count and the link-ready flag, and empties the output register.
module go_back_n_arq_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [arq_pkg::MODE_BITS-1:0] i_mode,
    input  logic                          i_frame_kind,
    input  logic [arq_pkg::SEQ_BITS-1:0]  i_frame_seq,
    input  logic [arq_pkg::SEQ_BITS-1:0]  i_frame_ack,
    input  logic                          i_frame_good,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [arq_pkg::ACT_BITS-1:0]  o_action,
    output logic [arq_pkg::SEQ_BITS-1:0]  o_seq_out,
    output logic [arq_pkg::SEQ_BITS-1:0]  o_ack_out,
    output logic [arq_pkg::SLOT_BITS-1:0] o_buffer_slot,
    output logic                          o_network_enable,
    output logic                          o_last
);

    logic             w_emit;
    logic             w_can_load;
    arq_pkg::t_result w_res;
    arq_pkg::t_result w_out;

    arq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_frame_kind (i_frame_kind),
        .i_frame_seq  (i_frame_seq),
        .i_frame_ack  (i_frame_ack),
        .i_frame_good (i_frame_good),
        .i_out_ready  (w_can_load),
        .o_emit       (w_emit),
        .o_res        (w_res)
    );

    arq_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_emit),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_out)
    );

    assign o_action         = w_out.action;
    assign o_seq_out        = w_out.seq;
    assign o_ack_out        = w_out.ack;
    assign o_buffer_slot    = w_out.slot;
    assign o_network_enable = w_out.en;
    assign o_last           = w_out.last;

endmodule

### sim/go_back_n_arq_controller_top_tb.sv
`timescale 1ns / 1ps

module go_back_n_arq_controller_top_tb;
    import arq_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED_LO = MODE_BITS'(int'(MODE_DATA_TIMEOUT) + 1);
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_HI = '1;
    localparam int DRAIN_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [MODE_BITS-1:0]  i_mode;
    logic                  i_frame_kind;
    logic [SEQ_BITS-1:0]   i_frame_seq;
    logic [SEQ_BITS-1:0]   i_frame_ack;
    logic                  i_frame_good;
    logic                  o_valid;
    logic                  i_ready;
    logic [ACT_BITS-1:0]   o_action;
    logic [SEQ_BITS-1:0]   o_seq_out;
    logic [SEQ_BITS-1:0]   o_ack_out;
    logic [SLOT_BITS-1:0]  o_buffer_slot;
    logic                  o_network_enable;
    logic                  o_last;

    t_result             pending_actions[$];
    logic [SEQ_BITS-1:0] win_base;
    logic [SEQ_BITS-1:0] win_next;
    logic [SEQ_BITS-1:0] rx_expected;
    int unsigned         win_count;
    bit                  link_up;

    int error_count;
    int events_sent;
    int items_checked;
    int deliveries;
    int data_sends;
    int stops;
    bit tx_gaps_on;
    bit rx_stalls_on;
    int hold_request;

    go_back_n_arq_controller_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_frame_kind     (i_frame_kind),
        .i_frame_seq      (i_frame_seq),
        .i_frame_ack      (i_frame_ack),
        .i_frame_good     (i_frame_good),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_action         (o_action),
        .o_seq_out        (o_seq_out),
        .o_ack_out        (o_ack_out),
        .o_buffer_slot    (o_buffer_slot),
        .o_network_enable (o_network_enable),
        .o_last           (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Timeout: controller stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [SEQ_BITS-1:0] piggy_ack();
        return rx_expected - 1'b1;
    endfunction

    function automatic bit seq_between(logic [SEQ_BITS-1:0] lo, logic [SEQ_BITS-1:0] x,
                                       logic [SEQ_BITS-1:0] hi);
        if (lo <= hi) return (lo <= x) && (x < hi);
        return (lo <= x) || (x < hi);
    endfunction

    function automatic void push_action(t_action act, logic [SEQ_BITS-1:0] seq,
                                        logic [SEQ_BITS-1:0] ack, logic [SLOT_BITS-1:0] slot,
                                        logic en, logic last);
        t_result r;
        r.action = act;
        r.seq    = seq;
        r.ack    = ack;
        r.slot   = slot;
        r.en     = en;
        r.last   = last;
        pending_actions.push_back(r);
    endfunction

    function automatic void queue_data_send(logic [SEQ_BITS-1:0] seq);
        push_action(ACT_SEND_DATA, seq, piggy_ack(), SLOT_BITS'(seq % WINDOW_SLOTS), 1'b0, 1'b0);
        link_up = 1'b0;
        data_sends++;
    endfunction

    function automatic void predict_event(logic [MODE_BITS-1:0] mode, logic kind,
                                          logic [SEQ_BITS-1:0] fseq, logic [SEQ_BITS-1:0] fack,
                                          logic good);
        logic [SEQ_BITS-1:0] s;
        case (mode)
            MODE_PKT_READY: begin
                if (win_count < WINDOW_SLOTS) begin
                    win_count++;
                    queue_data_send(win_next);
                    win_next = win_next + 1'b1;
                end
            end
            MODE_LINK_READY: begin
                link_up = 1'b1;
            end
            MODE_FRAME_RX: begin
                if (good) begin
                    while (win_count > 0 && seq_between(win_base, fack, win_next)) begin
                        push_action(ACT_STOP, win_base, '0, '0, 1'b0, 1'b0);
                        win_count--;
                        win_base = win_base + 1'b1;
                        stops++;
                    end
                    if (kind == KIND_DATA && fseq == rx_expected) begin
                        push_action(ACT_DELIVER, fseq, '0, '0, 1'b0, 1'b0);
                        rx_expected = rx_expected + 1'b1;
                        deliveries++;
                    end
                end
            end
            MODE_ACK_TIMEOUT: begin
                push_action(ACT_SEND_ACK, '0, piggy_ack(), '0, 1'b0, 1'b0);
                link_up = 1'b0;
            end
            MODE_DATA_TIMEOUT: begin
                s = win_base;
                for (int k = 0; k < int'(win_count); k++) begin
                    queue_data_send(s);
                    s = s + 1'b1;
                end
            end
            default: begin
            end
        endcase
        push_action(ACT_STATUS, '0, '0, '0, (win_count < WINDOW_SLOTS) && link_up, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_actions.size() == 0) begin
                $error("result item with nothing expected: action %0d seq %0d", o_action,
                       o_seq_out);
                error_count++;
            end else begin
                want = pending_actions.pop_front();
                check_field("action", want.action, o_action);
                check_field("seq_out", want.seq, o_seq_out);
                check_field("ack_out", want.ack, o_ack_out);
                check_field("buffer_slot", want.slot, o_buffer_slot);
                check_field("network_enable", want.en, o_network_enable);
                check_field("last", want.last, o_last);
                items_checked++;
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (rx_stalls_on) stall_left = pick_gap();
            end
        end
    end

    task automatic send_event(input logic [MODE_BITS-1:0] mode, input logic kind,
                              input logic [SEQ_BITS-1:0] fseq, input logic [SEQ_BITS-1:0] fack,
                              input logic good);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_frame_kind <= kind;
        i_frame_seq  <= fseq;
        i_frame_ack  <= fack;
        i_frame_good <= good;
        do @(posedge i_clk); while (!o_ready);
        predict_event(mode, kind, fseq, fack, good);
        events_sent++;
    endtask

    task automatic test_idle_events();
        send_event(MODE_UNUSED_LO, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_UNUSED_HI, ~KIND_DATA, '1, '1, 1'b1);
        send_event(MODE_ACK_TIMEOUT, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_DATA_TIMEOUT, ~KIND_DATA, '1, '1, 1'b1);
        send_event(MODE_FRAME_RX, ~KIND_DATA, '0, '1, 1'b1);
    endtask

    task automatic test_window_full();
        send_event(MODE_LINK_READY, KIND_DATA, '0, '0, 1'b0);
        repeat (WINDOW_SLOTS + 1) begin
            send_event(MODE_PKT_READY, KIND_DATA, '0, '0, 1'b0);
            send_event(MODE_LINK_READY, KIND_DATA, '0, '0, 1'b0);
        end
    endtask

    task automatic test_full_window_retire();
        send_event(MODE_DATA_TIMEOUT, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_FRAME_RX, ~KIND_DATA, '1, win_next - 1'b1, 1'b1);
    endtask

    task automatic test_frame_checks();
        send_event(MODE_FRAME_RX, KIND_DATA, rx_expected, win_base, 1'b0);
        send_event(MODE_PKT_READY, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_PKT_READY, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_FRAME_RX, KIND_DATA, rx_expected + 3'd3, win_base, 1'b1);
        send_event(MODE_FRAME_RX, KIND_DATA, rx_expected, win_base - 1'b1, 1'b1);
        send_event(MODE_DATA_TIMEOUT, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_FRAME_RX, KIND_DATA, rx_expected, win_base, 1'b1);
    endtask

    task automatic test_receiver_hold_off();
        tx_gaps_on = 1'b0;
        hold_request = 250;
        send_event(MODE_LINK_READY, KIND_DATA, '0, '0, 1'b0);
        repeat (3) send_event(MODE_PKT_READY, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_DATA_TIMEOUT, KIND_DATA, '0, '0, 1'b0);
        send_event(MODE_FRAME_RX, KIND_DATA, rx_expected, win_next - 1'b1, 1'b1);
        send_event(MODE_ACK_TIMEOUT, KIND_DATA, '0, '0, 1'b0);
        repeat (3) send_event(MODE_FRAME_RX, KIND_DATA, rx_expected, win_base, 1'b1);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int count);
        logic [MODE_BITS-1:0] mode;
        logic                 kind;
        logic                 good;
        logic [SEQ_BITS-1:0]  fseq;
        logic [SEQ_BITS-1:0]  fack;
        int                   pick;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                tx_gaps_on   = (n % 120 != 60);
                rx_stalls_on = (n % 120 != 60);
            end
            pick = $urandom_range(0, 99);
            kind = ($urandom_range(0, 9) < 3) ? ~KIND_DATA : KIND_DATA;
            good = ($urandom_range(0, 9) != 0);
            fseq = ($urandom_range(0, 9) < 6) ? rx_expected : SEQ_BITS'($urandom);
            fack = SEQ_BITS'($urandom);
            if (win_count > 0 && $urandom_range(0, 9) < 7)
                fack = win_base + SEQ_BITS'($urandom_range(0, win_count - 1));
            if (pick < 25)      mode = MODE_PKT_READY;
            else if (pick < 40) mode = MODE_LINK_READY;
            else if (pick < 80) mode = MODE_FRAME_RX;
            else if (pick < 87) mode = MODE_ACK_TIMEOUT;
            else if (pick < 95) mode = MODE_DATA_TIMEOUT;
            else mode = MODE_BITS'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            send_event(mode, kind, fseq, fack, good);
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic wait_drained();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (pending_actions.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_actions.size() != 0) begin
            $error("%0d result items never arrived", pending_actions.size());
            error_count++;
            pending_actions.delete();
        end
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = MODE_PKT_READY;
        i_frame_kind = KIND_DATA;
        i_frame_seq  = '0;
        i_frame_ack  = '0;
        i_frame_good = 1'b0;
        win_base     = '0;
        win_next     = '0;
        rx_expected  = '0;
        win_count    = 0;
        link_up      = 1'b0;
        error_count  = 0;
        events_sent  = 0;
        items_checked = 0;
        deliveries   = 0;
        data_sends   = 0;
        stops        = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        hold_request = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_events();
        test_window_full();
        test_full_window_retire();
        test_frame_checks();
        test_receiver_hold_off();
        test_random_traffic(300);
        wait_drained();

        $display("Sent %0d link events; checked %0d result items.", events_sent, items_checked);
        $display("Saw %0d data sends, %0d timer stops and %0d deliveries.", data_sends, stops,
                 deliveries);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/arq_pkg.sv
rtl/arq_win_unit.sv
rtl/arq_ctrl.sv
rtl/arq_out_reg.sv
rtl/go_back_n_arq_controller_top.sv
sim/go_back_n_arq_controller_top_tb.sv
